>>> rtl/core/pidtc_pkg.sv
// shared types and constants of the pid temperature controller
`default_nettype none

package pidtc_pkg;

    localparam int GAIN_W     = 16;
    localparam int TEMP_W     = 16;
    localparam int ELAPSED_W  = 16;
    localparam int ERR_W      = TEMP_W + 1;
    localparam int DIFF_W     = ERR_W + 1;
    localparam int DEN_W      = 26;
    localparam int DRIVE_W    = 40;
    localparam int OUT_FRAC   = 16;
    localparam int DERIV_FRAC = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int N_TERMS    = 3;
    localparam int TERM_W     = 2;

    localparam logic [TERM_W-1:0] TERM_P = 2'd0;
    localparam logic [TERM_W-1:0] TERM_I = 2'd1;
    localparam logic [TERM_W-1:0] TERM_D = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INTEG,
        ST_DIV,
        ST_MAC_GO,
        ST_MAC,
        ST_TRUNC,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

>>> rtl/core/pidtc_div.sv
// radix-2 restoring divider, one quotient bit per cycle
`default_nettype none

module pidtc_div #(
    parameter int NUM_W = 33
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [NUM_W-1:0]          num,
    input  logic [pidtc_pkg::DEN_W-1:0] den,
    output pidtc_pkg::unit_stat_t     stat,
    output logic [NUM_W-1:0]          quo
);
    import pidtc_pkg::*;

    localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   trial_sub;
    logic             fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        trial_sub = trial - {1'b0, den_reg};
        fits      = (trial >= {1'b0, den_reg});
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CNT_W'(NUM_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NUM_W-2:0], fits};
            rem_next = fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;

endmodule

`default_nettype wire

>>> rtl/core/pidtc_mac.sv
// shared multiplier and accumulator, one gain term per cycle
`default_nettype none

module pidtc_mac #(
    parameter int MB_W  = 25,
    parameter int ACC_W = 50,
    parameter int SHIFT = 16
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           start,
    input  logic [pidtc_pkg::N_TERMS-1:0][pidtc_pkg::GAIN_W-1:0] mul_a,
    input  logic [pidtc_pkg::N_TERMS-1:0][MB_W-1:0]        mul_b,
    output pidtc_pkg::unit_stat_t                          stat,
    output logic signed [ACC_W-1:0]                        acc
);
    import pidtc_pkg::*;

    localparam int PROD_W = GAIN_W + MB_W;

    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [TERM_W-1:0]        term_reg, term_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic [TERM_W-1:0]        cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [TERM_W-1:0]        sel;
    logic signed [ACC_W-1:0]  term_ext;
    logic signed [ACC_W-1:0]  term_scaled;

    always_comb
    begin
        sel         = (cnt_reg == TERM_W'(N_TERMS)) ? TERM_P : cnt_reg;
        term_ext    = ACC_W'(prod_reg);
        term_scaled = (term_reg == TERM_D) ? term_ext : (term_ext <<< SHIFT);
        prod_next   = prod_reg;
        term_next   = term_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != TERM_W'(N_TERMS))
            begin
                prod_next = $signed(mul_a[sel]) * $signed(mul_b[sel]);
                term_next = sel;
            end
            if (cnt_reg != '0)
            begin
                acc_next = acc_reg + term_scaled;
            end
            if (cnt_reg == TERM_W'(N_TERMS))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        term_reg <= term_next;
        acc_reg  <= acc_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign acc       = acc_reg;

endmodule

`default_nettype wire

>>> rtl/core/pid_temperature_controller.sv
// top level of the pid temperature controller: sequencer, state and output register
//
// channel   | dir | fields (low bit first)
// s_*       | in  | setpoint[15:0], measured[31:16], elapsed_ms[47:32]
// m_*       | out | drive[39:0]
// wr_*      | in  | gain_p, gain_i, gain_d by wr_index, no read-back
//
// one transfer runs from accept to the next s_tready through the integral step, the divider
// with its 41 - TEMP_FRAC_BITS quotient steps, then the shared multiplier, truncation and output
// zero elapsed time skips the divider
// s_tready is high only while the sequencer is idle; a held result stalls its end
// reset clears gains, integral and previous error; no clearing pass
`default_nettype none

module pid_temperature_controller #(
    parameter int TEMP_FRAC_BITS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [47:0]                          s_tdata,   // setpoint, measured, elapsed_ms
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [39:0]                          m_tdata,   // drive
    input  logic                                 wr_en,
    input  logic [pidtc_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [pidtc_pkg::GAIN_W-1:0]         wr_data
);
    import pidtc_pkg::*;

    localparam int F        = TEMP_FRAC_BITS;
    localparam int INT_TOP  = 100 << F;
    localparam int INT_W    = $clog2(INT_TOP + 1);
    localparam int IS_W     = ((INT_W > ERR_W) ? INT_W : ERR_W) + 2;
    localparam int MAG_W    = (ERR_W) + DERIV_FRAC - F;
    localparam int NUM_SH   = DERIV_FRAC - F;
    localparam int DER_W    = 33 - F;
    localparam int MB_A     = (DER_W > INT_W + 1) ? DER_W : INT_W + 1;
    localparam int MB_W     = (MB_A > ERR_W) ? MB_A : ERR_W;
    localparam int TOP_BIT  = ((55 - F) > 47) ? (55 - F) : 47;
    localparam int ACC_W    = TOP_BIT + 3;
    localparam int RES_W    = ACC_W - OUT_FRAC;
    localparam int SAT_W    = (RES_W > DRIVE_W) ? RES_W : DRIVE_W;
    localparam int P_SHIFT  = 32 - 8 - F;

    localparam logic signed [ERR_W-1:0] WIN_HI = ERR_W'(3 << F);
    localparam logic signed [ERR_W-1:0] WIN_LO = -WIN_HI;
    localparam logic signed [IS_W-1:0]  TOP_S  = IS_W'(INT_TOP);
    localparam logic [INT_W-1:0]        TOP_U  = INT_W'(INT_TOP);
    localparam logic signed [SAT_W-1:0] DRV_MAX =
        {{(SAT_W - DRIVE_W + 1){1'b0}}, {(DRIVE_W - 1){1'b1}}};
    localparam logic signed [SAT_W-1:0] DRV_MIN =
        {{(SAT_W - DRIVE_W + 1){1'b1}}, {(DRIVE_W - 1){1'b0}}};

    state_t                     state_reg, state_next;
    logic signed [GAIN_W-1:0]   gain_p_reg, gain_i_reg, gain_d_reg;
    logic [INT_W-1:0]           integ_reg, integ_next;
    logic signed [ERR_W-1:0]    prev_reg, prev_next;
    logic signed [ERR_W-1:0]    err_reg, err_next;
    logic [ELAPSED_W-1:0]       el_reg, el_next;
    logic                       neg_reg, neg_next;
    logic signed [DER_W-1:0]    deriv_reg, deriv_next;
    logic signed [RES_W-1:0]    res_reg, res_next;
    logic [DRIVE_W-1:0]         drive_reg, drive_next;
    logic                       m_valid_reg, m_valid_next;

    logic signed [TEMP_W-1:0]   sp_in, ms_in;
    logic signed [IS_W-1:0]     isum;
    logic                       in_win;
    logic signed [DIFF_W-1:0]   diff;
    logic [DIFF_W-1:0]          diff_abs;
    logic [MAG_W-1:0]           div_num;
    logic [DEN_W-1:0]           el_ext;
    logic [DEN_W-1:0]           div_den;
    logic                       div_start;
    logic                       mac_start;
    unit_stat_t                 div_stat, mac_stat;
    logic [MAG_W-1:0]           div_quo;
    logic signed [DER_W-1:0]    quo_pos;
    logic signed [ACC_W-1:0]    mac_acc;
    logic signed [ACC_W-1:0]    acc_adj;
    logic signed [SAT_W-1:0]    res_ext;
    logic [N_TERMS-1:0][GAIN_W-1:0] mul_a;
    logic [N_TERMS-1:0][MB_W-1:0]   mul_b;

    assign sp_in    = s_tdata[15:0];
    assign ms_in    = s_tdata[31:16];
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = drive_reg;

    // gain registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_GAIN_P: gain_p_reg <= wr_data;
                REG_GAIN_I: gain_i_reg <= wr_data;
                REG_GAIN_D: gain_d_reg <= wr_data;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        in_win   = (err_reg > WIN_LO) && (err_reg < WIN_HI);
        isum     = IS_W'({1'b0, integ_reg}) + (in_win ? IS_W'(err_reg) : IS_W'(0));
        diff     = DIFF_W'(err_reg) - DIFF_W'(prev_reg);
        diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        div_num  = MAG_W'(diff_abs[ERR_W-1:0]) << NUM_SH;
        el_ext   = DEN_W'(el_reg);
        // elapsed times 1000
        div_den  = (el_ext << 10) - (el_ext << 4) - (el_ext << 3);
        quo_pos  = {1'b0, div_quo[DER_W-2:0]};
        acc_adj  = mac_acc + (mac_acc[ACC_W-1] ? ACC_W'((1 << OUT_FRAC) - 1) : ACC_W'(0));
        res_ext  = SAT_W'(res_reg);
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        integ_next   = integ_reg;
        prev_next    = prev_reg;
        err_next     = err_reg;
        el_next      = el_reg;
        neg_next     = neg_reg;
        deriv_next   = deriv_reg;
        res_next     = res_reg;
        drive_next   = drive_reg;
        m_valid_next = m_valid_reg && !m_tready;
        div_start    = 1'b0;
        mac_start    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    err_next   = ERR_W'(sp_in) - ERR_W'(ms_in);
                    el_next    = s_tdata[47:32];
                    state_next = ST_INTEG;
                end
            end
            ST_INTEG:
            begin
                if (isum < 0)
                begin
                    integ_next = '0;
                end
                else if (isum > TOP_S)
                begin
                    integ_next = TOP_U;
                end
                else
                begin
                    integ_next = isum[INT_W-1:0];
                end
                prev_next = err_reg;
                neg_next  = diff[DIFF_W-1];
                if (el_reg != '0)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    deriv_next = '0;
                    state_next = ST_MAC_GO;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    deriv_next = neg_reg ? -quo_pos : quo_pos;
                    state_next = ST_MAC_GO;
                end
            end
            ST_MAC_GO:
            begin
                mac_start  = 1'b1;
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                if (mac_stat.done)
                begin
                    state_next = ST_TRUNC;
                end
            end
            ST_TRUNC:
            begin
                // toward zero
                res_next   = acc_adj[ACC_W-1:OUT_FRAC];
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    if (res_ext > DRV_MAX)
                    begin
                        drive_next = DRV_MAX[DRIVE_W-1:0];
                    end
                    else if (res_ext < DRV_MIN)
                    begin
                        drive_next = DRV_MIN[DRIVE_W-1:0];
                    end
                    else
                    begin
                        drive_next = res_ext[DRIVE_W-1:0];
                    end
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            integ_reg   <= '0;
            prev_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            integ_reg   <= integ_next;
            prev_reg    <= prev_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg   <= err_next;
        el_reg    <= el_next;
        neg_reg   <= neg_next;
        deriv_reg <= deriv_next;
        res_reg   <= res_next;
        drive_reg <= drive_next;
    end

    assign mul_a[TERM_P] = gain_p_reg;
    assign mul_a[TERM_I] = gain_i_reg;
    assign mul_a[TERM_D] = gain_d_reg;
    assign mul_b[TERM_P] = MB_W'(err_reg);
    assign mul_b[TERM_I] = MB_W'({1'b0, integ_reg});
    assign mul_b[TERM_D] = MB_W'(deriv_reg);

    pidtc_div #(
        .NUM_W (MAG_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    pidtc_mac #(
        .MB_W  (MB_W),
        .ACC_W (ACC_W),
        .SHIFT (P_SHIFT)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mac_start),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .stat  (mac_stat),
        .acc   (mac_acc)
    );

    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output step");

    a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
        integ_reg <= TOP_U)
        else $error("integral above its clamp");

    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == ST_DIV))
        else $error("divider running outside its step");

    a_mac_owned: assert property (@(posedge clk) disable iff (!rst_n)
        mac_stat.busy |-> (state_reg == ST_MAC))
        else $error("multiplier running outside its step");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && m_valid_reg && !m_tready) |=> (state_reg == ST_OUT))
        else $error("new result overwrote a held transfer");

endmodule

`default_nettype wire

>>> tb/sv/pid_temperature_controller_tb.sv
// testbench of the pid temperature controller: directed table, then randomized updates checked by a drive predictor
`default_nettype none

module pid_temperature_controller_tb;

    import pidtc_pkg::*;

    localparam int TEMP_FRAC    = 8;
    localparam int SETTLE       = 64;
    localparam int WATCHDOG     = 4000;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 600;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 150;
    localparam int MAX_REPORTS  = 10;

    localparam longint WINDOW    = 3 * (longint'(1) <<< TEMP_FRAC);
    localparam longint CEILING   = 100 * (longint'(1) <<< TEMP_FRAC);
    localparam longint DRIVE_MAX = (longint'(1) <<< (DRIVE_W - 1)) - 1;
    localparam longint DRIVE_MIN = -(longint'(1) <<< (DRIVE_W - 1));

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam logic [15:0] TEMP_EXTREMES [4] = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};
    localparam logic [15:0] GAIN_EXTREMES [4] = '{16'h7fff, 16'h8000, 16'h0000, 16'h0100};

    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   index;
        logic [GAIN_W-1:0]      value;
        logic [15:0]            setpoint;
        logic [15:0]            measured;
        logic [15:0]            elapsed;
        bit                     has_drive;
        logic [DRIVE_W-1:0]     drive;
    } row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [47:0]            s_tdata;    // setpoint, measured, elapsed_ms
    logic                   m_tvalid;
    logic                   m_tready;
    logic [39:0]            m_tdata;    // drive
    logic                   wr_en;
    logic [CFG_IDX_W-1:0]   wr_index;
    logic [GAIN_W-1:0]      wr_data;

    logic signed [15:0]     gain_p;
    logic signed [15:0]     gain_i;
    logic signed [15:0]     gain_d;
    longint                 integ_acc;
    longint                 last_error;

    logic [DRIVE_W-1:0]     drive_expected [$];
    row_t                   plan [$];

    int                     updates_sent;
    int                     drives_checked;
    int                     gain_writes;
    int                     mismatches;
    int                     idle_cycles;
    bit                     settled;
    bit                     tx_fast;
    bit                     rx_fast;
    bit                     held;

    pid_temperature_controller #(
        .TEMP_FRAC_BITS (TEMP_FRAC)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic logic [DRIVE_W-1:0] predict_drive(logic signed [15:0] sp,
                                                         logic signed [15:0] ms,
                                                         logic [15:0] el);
        longint err;
        longint slope;
        longint acc;
        longint res;
        err = longint'(sp) - longint'(ms);
        if (err > -WINDOW && err < WINDOW)
            integ_acc += err;
        if (integ_acc < 0)
            integ_acc = 0;
        else if (integ_acc > CEILING)
            integ_acc = CEILING;
        slope = 0;
        if (el != 0)
            slope = ((err - last_error) * (longint'(1) <<< (DERIV_FRAC - TEMP_FRAC)))
                    / (longint'(el) * 1000);
        acc = (longint'(gain_p) * err + longint'(gain_i) * integ_acc)
              * (longint'(1) <<< (24 - TEMP_FRAC))
              + longint'(gain_d) * slope;
        res = acc / 65536;
        if (res > DRIVE_MAX)
            res = DRIVE_MAX;
        else if (res < DRIVE_MIN)
            res = DRIVE_MIN;
        last_error = err;
        return res[DRIVE_W-1:0];
    endfunction

    function automatic logic [GAIN_W-1:0] draw_gain(int style);
        logic [GAIN_W-1:0] g;
        case (style)
            0:       g = GAIN_W'($urandom);
            1:       g = GAIN_EXTREMES[$urandom_range(0, 3)];
            default: g = GAIN_W'(int'($urandom_range(0, 1023)) - 512);
        endcase
        return g;
    endfunction

    // mostly tracking updates near the integral window, the rest noise and extremes
    task automatic draw_update(input int lean, output logic [15:0] sp, output logic [15:0] ms,
                               output logic [15:0] el);
        int s;
        int d;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
            begin
                s = int'($urandom_range(0, 60000)) - 30000;
                case ($urandom_range(0, 7))
                    0:       d = 768;
                    1:       d = -768;
                    2:       d = 767;
                    3:       d = -767;
                    default: d = int'($urandom_range(0, 1500)) - lean;
                endcase
                sp = s[15:0];
                ms = 16'(s - d);
                el = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom_range(1, 2000));
            end
            6, 7:
            begin
                sp = 16'($urandom);
                ms = 16'($urandom);
                el = 16'($urandom);
            end
            8:
            begin
                sp = TEMP_EXTREMES[$urandom_range(0, 3)];
                ms = TEMP_EXTREMES[$urandom_range(0, 3)];
                el = ($urandom_range(0, 1) == 1) ? 16'hffff : 16'd1;
            end
            default:
            begin
                sp = 16'($urandom);
                ms = 16'($urandom);
                el = ($urandom_range(0, 1) == 1) ? 16'hffff : 16'd0;
            end
        endcase
    endtask

    // stop offering, let every drive value come back and the sequencer settle
    task automatic quiesce();
        if (!settled)
        begin
            s_tvalid <= 1'b0;
            while (drive_expected.size() != 0)
                @(posedge clk);
            repeat (SETTLE) @(posedge clk);
            settled = 1'b1;
        end
    endtask

    task automatic write_gain(logic [CFG_IDX_W-1:0] index, logic [GAIN_W-1:0] value);
        quiesce();
        wr_en    <= 1'b1;
        wr_index <= index;
        wr_data  <= value;
        @(posedge clk);
        case (index)
            REG_GAIN_P: gain_p = value;
            REG_GAIN_I: gain_i = value;
            REG_GAIN_D: gain_d = value;
            default:    ;
        endcase
        gain_writes++;
    endtask

    task automatic send_update(logic [15:0] sp, logic [15:0] ms, logic [15:0] el,
                               bit has_drive, logic [DRIVE_W-1:0] drive);
        logic [DRIVE_W-1:0] predicted;
        int gap;
        wr_en    <= 1'b0;
        settled  = 1'b0;
        s_tvalid <= 1'b1;
        s_tdata  <= {el, ms, sp};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = predict_drive(sp, ms, el);
        drive_expected.push_back(has_drive ? drive : predicted);
        updates_sent++;
        gap = tx_fast ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic void plan_cfg(logic [CFG_IDX_W-1:0] index, logic [GAIN_W-1:0] value);
        row_t r;
        r = '{kind: ROW_CFG, index: index, value: value, default: '0};
        plan.push_back(r);
    endfunction

    function automatic void plan_item(logic [15:0] sp, logic [15:0] ms, logic [15:0] el,
                                      bit has_drive = 1'b0, logic [DRIVE_W-1:0] drive = '0);
        row_t r;
        r = '{kind: ROW_ITEM, index: '0, value: '0, setpoint: sp, measured: ms, elapsed: el,
              has_drive: has_drive, drive: drive};
        plan.push_back(r);
    endfunction

    task automatic report_mismatch(logic [DRIVE_W-1:0] want, logic [DRIVE_W-1:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on drive %0d: expected %h, got %h", drives_checked, want, got);
    endtask

    // result side
    initial
    begin
        int stall;
        logic [DRIVE_W-1:0] want;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (drives_checked == HOLD_AT && !held)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall = rx_fast ? 0 : $urandom_range(0, 17);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            if (drive_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected drive transfer %h", m_tdata);
            end
            else
            begin
                want = drive_expected.pop_front();
                if (m_tdata !== want)
                    report_mismatch(want, m_tdata);
            end
            drives_checked++;
            if (drives_checked % 100 == 0)
                rx_fast = ($urandom_range(0, 3) == 0);
        end
    end

    // no transfer on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        logic [15:0] sp;
        logic [15:0] ms;
        logic [15:0] el;
        int lean;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        wr_en    <= 1'b0;
        wr_index <= '0;
        wr_data  <= '0;
        rst_n    <= 1'b0;
        gain_p = '0;
        gain_i = '0;
        gain_d = '0;
        integ_acc = 0;
        last_error = 0;
        updates_sent = 0;
        drives_checked = 0;
        gain_writes = 0;
        mismatches = 0;
        idle_cycles = 0;
        settled = 1'b1;
        tx_fast = 1'b0;
        rx_fast = 1'b0;
        held = 1'b0;

        // gains zero after reset, then unity proportional gain on full-scale error
        plan_item(16'h0000, 16'h0000, 16'h0000, 1'b1, 40'd0);
        plan_item(16'h7fff, 16'h8000, 16'h0001, 1'b1, 40'd0);
        plan_cfg(REG_GAIN_P, 16'h0100);
        plan_item(16'h7fff, 16'h8000, 16'h0005, 1'b1, 40'd16776960);
        plan_item(16'h8000, 16'h7fff, 16'h0005, 1'b1, -40'sd16776960);
        plan_item(16'h0300, 16'h0300, 16'h0000, 1'b1, 40'd0);
        // extreme gains, window edges, zero and full elapsed, largest error swings
        plan_cfg(REG_GAIN_P, 16'h8000);
        plan_cfg(REG_GAIN_I, 16'h7fff);
        plan_cfg(REG_GAIN_D, 16'h7fff);
        plan_cfg(REG_UNUSED, 16'h1234);
        plan_item(16'h0300, 16'h0000, 16'd10);
        plan_item(16'h0000, 16'h0300, 16'd10);
        plan_item(16'h02ff, 16'h0000, 16'd0);
        plan_item(16'h02ff, 16'h0000, 16'd1);
        plan_item(16'h0000, 16'h02ff, 16'hffff);
        plan_item(16'h7fff, 16'h8000, 16'd1);
        plan_item(16'h8000, 16'h7fff, 16'd1);
        plan_item(16'h0000, 16'h0000, 16'hffff);
        plan_cfg(REG_GAIN_P, 16'h7fff);
        plan_cfg(REG_GAIN_I, 16'h8000);
        plan_cfg(REG_GAIN_D, 16'h8000);
        plan_item(16'h0064, 16'h0000, 16'd1);
        plan_item(16'h7fff, 16'h7fff, 16'd2);
        plan_item(16'h8000, 16'h8000, 16'd0);
        plan_item(16'h8000, 16'h7fff, 16'hffff);
        plan_item(16'h7fff, 16'h8000, 16'h8000);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[k])
        begin
            if (plan[k].kind == ROW_CFG)
                write_gain(plan[k].index, plan[k].value);
            else
                send_update(plan[k].setpoint, plan[k].measured, plan[k].elapsed,
                            plan[k].has_drive, plan[k].drive);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_gain(REG_GAIN_P, draw_gain(ph % 3));
            write_gain(REG_GAIN_I, draw_gain(ph % 3));
            write_gain(REG_GAIN_D, draw_gain(ph % 3));
            if (ph == 4)
                write_gain(REG_UNUSED, GAIN_W'($urandom));
            tx_fast = (ph % 4 == 3);
            case (ph % 3)
                0:       lean = 100;
                1:       lean = 1400;
                default: lean = 750;
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                draw_update(lean, sp, ms, el);
                send_update(sp, ms, el, 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        while (drive_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (drive_expected.size() != 0)
            mismatches++;

        $display("summary: %0d updates over %0d gain settings, %0d drive values checked",
                 updates_sent, gain_writes, drives_checked);
        $display("summary: window edges, integral clamps, zero and full elapsed time, %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
rtl/core/pidtc_pkg.sv
rtl/core/pidtc_div.sv
rtl/core/pidtc_mac.sv
rtl/core/pid_temperature_controller.sv
tb/sv/pid_temperature_controller_tb.sv
